[src/navigation_history_ring_macros.svh]
// Assertion macros shared by the navigation history ring checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef NAVIGATION_HISTORY_RING_MACROS_SVH
`define NAVIGATION_HISTORY_RING_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NHR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("navigation_history_ring: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NHR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("navigation_history_ring: assertion failed");

`endif

[src/nhr_pkg.sv]
// Shared types for the navigation history ring: operation codes, word structs,
// controller states and the command group. No dependencies.
`timescale 1ns / 1ps

package nhr_pkg;

  typedef enum logic [1:0] {
    OP_SAVE = 2'd0,
    OP_FWD  = 2'd1,
    OP_BACK = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] position;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] target;
  } out_item_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

endpackage

[src/nhr_ctrl.sv]
// Controller of the navigation history ring: accepts one word, then executes it
// once the output register is free. Depends on nhr_pkg.
`timescale 1ns / 1ps

module nhr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output nhr_pkg::ctrl_cmd_t cmd_o
);

  nhr_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nhr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      nhr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = nhr_pkg::ST_EXEC;
        end
      end
      nhr_pkg::ST_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = nhr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = nhr_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[src/nhr_datapath.sv]
// Datapath of the navigation history ring: slot memory with two registered read
// ports, the three ring pointers and the output word register. Depends on nhr_pkg.
`timescale 1ns / 1ps

module nhr_datapath #(
  parameter int DEPTH    = 32,
  parameter int POS_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nhr_pkg::ctrl_cmd_t cmd_i,
  input  nhr_pkg::in_item_t  in_data_i,
  output nhr_pkg::out_item_t out_data_o
);

  localparam int PTR_W = $clog2(DEPTH);

  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [POS_BITS-1:0] pos_t;

  function automatic ptr_t ring_next(input ptr_t p);
    ring_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t ring_prev(input ptr_t p);
    ring_prev = (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  // An unwritten slot may be read, but its value never reaches the output, so the memory needs no clearing.
  pos_t mem_q [DEPTH];

  ptr_t               oldest_q, oldest_d;
  ptr_t               newest_q, newest_d;
  ptr_t               here_q, here_d;
  logic [1:0]         op_q;
  logic [31:0]        pos_q;
  pos_t               rda_q, rdb_q;
  nhr_pkg::out_item_t out_q, out_d;

  ptr_t rd_addr_a;
  ptr_t next_here, next_newest, next_oldest, prev_here;
  pos_t stored;
  logic wr_en;
  ptr_t wr_addr;

  assign next_here   = ring_next(here_q);
  assign next_newest = ring_next(newest_q);
  assign next_oldest = ring_next(oldest_q);
  assign prev_here   = ring_prev(here_q);
  assign stored      = POS_BITS'(pos_q);

  assign rd_addr_a = (in_data_i.operation == nhr_pkg::OP_FWD) ? next_here : here_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= stored;
    end
    if (cmd_i.capture) begin
      rda_q <= mem_q[rd_addr_a];
      rdb_q <= mem_q[prev_here];
      op_q  <= in_data_i.operation;
      pos_q <= in_data_i.position;
    end
    if (cmd_i.exec) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      newest_q <= '0;
      here_q   <= '0;
    end else if (cmd_i.exec) begin
      oldest_q <= oldest_d;
      newest_q <= newest_d;
      here_q   <= here_d;
    end
  end

  always_comb begin
    oldest_d     = oldest_q;
    newest_d     = newest_q;
    here_d       = here_q;
    wr_en        = 1'b0;
    wr_addr      = next_here;
    out_d.ok     = 1'b0;
    out_d.target = pos_q;
    case (op_q)
      nhr_pkg::OP_SAVE: begin
        here_d   = next_here;
        newest_d = next_here;
        wr_en    = cmd_i.exec;
        wr_addr  = next_here;
        if (oldest_q == next_here) begin
          oldest_d = next_oldest;
        end
        out_d.ok = 1'b1;
      end
      nhr_pkg::OP_FWD: begin
        if (here_q != newest_q) begin
          here_d       = next_here;
          out_d.ok     = 1'b1;
          out_d.target = 32'(rda_q);
        end
      end
      nhr_pkg::OP_BACK: begin
        if (newest_q != oldest_q) begin
          if (here_q == newest_q && rda_q != stored) begin
            newest_d     = next_newest;
            wr_en        = cmd_i.exec;
            wr_addr      = next_newest;
            if (oldest_q == next_newest) begin
              oldest_d = next_oldest;
            end
            out_d.ok     = 1'b1;
            out_d.target = 32'(rda_q);
          end else if (prev_here != oldest_q) begin
            here_d       = prev_here;
            out_d.ok     = 1'b1;
            out_d.target = 32'(rdb_q);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_data_o = out_q;

endmodule

[src/navigation_history_ring.sv]
// Top level of the navigation history ring: controller plus datapath.
// Depends on nhr_pkg, nhr_ctrl and nhr_datapath.
// Each word is first captured with a registered read of the slots at and around the current position;
// once the output register is free, the pointers are updated, the slot is written and the output register is loaded.
`timescale 1ns / 1ps

module navigation_history_ring #(
  parameter int DEPTH    = 32,
  parameter int POS_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  nhr_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output nhr_pkg::out_item_t out_data_o
);

  nhr_pkg::ctrl_cmd_t cmd;

  nhr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  nhr_datapath #(
    .DEPTH    (DEPTH),
    .POS_BITS (POS_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

[src/nhr_checker.sv]
// Port-level checker for the navigation history ring, bound to the top level.
// Depends on nhr_pkg and navigation_history_ring_macros.svh.
`timescale 1ns / 1ps
`include "navigation_history_ring_macros.svh"

module nhr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input nhr_pkg::out_item_t out_data_o
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  `NHR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `NHR_ASSERT_NEXT(a_one_at_a_time, in_acc, !in_ready_o)
  `NHR_ASSERT_NEXT(a_exec_waits, !in_ready_o && out_valid_o && !out_ready_i, !in_ready_o)
  `NHR_ASSERT_NOW(a_result_after_exec, $rose(out_valid_o), $past(!in_ready_o))

endmodule

bind navigation_history_ring nhr_checker u_nhr_checker (.*);

[tb/sv/navigation_history_ring_test.sv]
// Self-checking testbench for navigation_history_ring: random and directed
// save/forward/back words and unused operation codes, scoreboarded against an in-bench history predictor.
// Depends on nhr_pkg and the navigation_history_ring RTL.
`timescale 1ns / 1ps

module navigation_history_ring_test;
  import nhr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RING_SLOTS = 32;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_LIMIT = 5000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  logic [31:0] nav_slots [RING_SLOTS];
  logic [4:0]  oldest_idx;
  logic [4:0]  newest_idx;
  logic [4:0]  here_idx;

  out_item_t pending_moves[$];
  int        failures;
  int        tx_gap_max;
  int        rx_stall_max;
  int        rx_stall_left;
  int        rx_hold_left;

  logic [31:0] pos_pool [8];

  navigation_history_ring dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic out_item_t predict_move(in_item_t w);
    out_item_t  res;
    logic       moved;
    logic [4:0] back_idx;
    res.ok     = 1'b0;
    res.target = w.position;
    case (w.operation)
      OP_SAVE: begin
        here_idx = here_idx + 5'd1;
        newest_idx = here_idx;
        nav_slots[here_idx] = w.position;
        if (oldest_idx == newest_idx) begin
          oldest_idx = oldest_idx + 5'd1;
        end
        res.ok = 1'b1;
      end
      OP_FWD: begin
        if (here_idx != newest_idx) begin
          here_idx = here_idx + 5'd1;
          res.ok = 1'b1;
          res.target = nav_slots[here_idx];
        end
      end
      OP_BACK: begin
        if (newest_idx != oldest_idx) begin
          moved = 1'b1;
          if (here_idx == newest_idx && nav_slots[here_idx] != w.position) begin
            newest_idx = newest_idx + 5'd1;
            nav_slots[newest_idx] = w.position;
            if (oldest_idx == newest_idx) begin
              oldest_idx = oldest_idx + 5'd1;
            end
          end else begin
            back_idx = here_idx - 5'd1;
            if (back_idx == oldest_idx) begin
              moved = 1'b0;
            end else begin
              here_idx = back_idx;
            end
          end
          if (moved) begin
            res.ok = 1'b1;
            res.target = nav_slots[here_idx];
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // The valid line is left high on return so that a zero gap keeps the channel
  // busy; a later call with a nonzero gap, wait_for_results or the end of the run lowers it.
  task automatic send_word(input logic [1:0] op, input logic [31:0] pos);
    int       gap;
    in_item_t w;
    gap = $urandom_range(0, tx_gap_max);
    w.operation = op;
    w.position = pos;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = w;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    pending_moves.push_back(predict_move(w));
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    in_valid_i = 1'b0;
    while (pending_moves.size() > 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_position(input logic [1:0] op);
    int r;
    r = $urandom_range(0, 99);
    if (op == OP_BACK && r < 40) begin
      return nav_slots[here_idx];
    end else if (r < 75) begin
      return pos_pool[$urandom_range(0, 7)];
    end
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_operation();
    int r;
    r = $urandom_range(0, 99);
    if (r < 38) begin
      return OP_SAVE;
    end else if (r < 72) begin
      return OP_BACK;
    end else if (r < 95) begin
      return OP_FWD;
    end
    return OP_UNUSED;
  endfunction

  task automatic test_empty_history();
    send_word(OP_BACK, 32'hFFFF_FFFF);
    send_word(OP_FWD, 32'h0000_0000);
    send_word(OP_UNUSED, 32'hFFFF_FFFF);
    send_word(OP_UNUSED, 32'h0000_0000);
  endtask

  task automatic test_save_and_walk();
    send_word(OP_SAVE, 32'h0000_0000);
    send_word(OP_SAVE, 32'hFFFF_FFFF);
    send_word(OP_SAVE, 32'hA5A5_A5A5);
    send_word(OP_FWD, 32'h1111_1111);
    send_word(OP_BACK, 32'hA5A5_A5A5);
    send_word(OP_BACK, 32'h8000_0000);
    send_word(OP_BACK, 32'h0000_0001);
    send_word(OP_FWD, 32'h0000_0000);
    send_word(OP_FWD, 32'h0000_0000);
    send_word(OP_FWD, 32'h7FFF_FFFF);
  endtask

  task automatic test_back_append();
    send_word(OP_BACK, 32'h1234_5678);
    send_word(OP_FWD, 32'h0000_0000);
    send_word(OP_BACK, 32'h1234_5678);
    send_word(OP_SAVE, 32'h5A5A_5A5A);
    send_word(OP_FWD, 32'hFFFF_FFFF);
    send_word(OP_UNUSED, 32'h5A5A_5A5A);
  endtask

  task automatic test_wraparound();
    int i;
    tx_gap_max = 0;
    rx_stall_max = 0;
    for (i = 0; i < 40; i++) begin
      send_word(OP_SAVE, $urandom);
    end
    send_word(OP_BACK, ~nav_slots[here_idx]);
    for (i = 0; i < 34; i++) begin
      send_word(OP_BACK, nav_slots[here_idx]);
    end
    for (i = 0; i < 5; i++) begin
      send_word(OP_FWD, $urandom);
    end
    tx_gap_max = 10;
    rx_stall_max = 10;
  endtask

  task automatic test_backpressure();
    int       i;
    logic [1:0] op;
    wait_for_results();
    tx_gap_max = 0;
    rx_hold_left = 80;
    for (i = 0; i < 40; i++) begin
      op = pick_operation();
      send_word(op, pick_position(op));
    end
    wait_for_results();
    tx_gap_max = 10;
  endtask

  task automatic test_random_walk();
    int       blk;
    int       i;
    logic [1:0] op;
    for (blk = 0; blk < 14; blk++) begin
      case ($urandom_range(0, 3))
        0: begin
          tx_gap_max = 0;
          rx_stall_max = 0;
        end
        1: begin
          tx_gap_max = 10;
          rx_stall_max = 0;
        end
        2: begin
          tx_gap_max = 0;
          rx_stall_max = 10;
        end
        default: begin
          tx_gap_max = 10;
          rx_stall_max = 10;
        end
      endcase
      for (i = 0; i < 30; i++) begin
        op = pick_operation();
        send_word(op, pick_position(op));
      end
    end
  endtask

  initial begin
    rx_stall_left = 0;
    rx_hold_left = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        out_ready_i = 1'b0;
        rx_hold_left--;
      end else if (rx_stall_left > 0) begin
        out_ready_i = 1'b0;
        rx_stall_left--;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      rx_stall_left = $urandom_range(0, rx_stall_max);
      if (pending_moves.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected word: ok=%0b target=%08h", out_data_o.ok, out_data_o.target);
        end
      end else begin
        want = pending_moves.pop_front();
        if (out_data_o.ok !== want.ok || out_data_o.target !== want.target) begin
          failures++;
          if (failures <= 10) begin
            $display("mismatch: expected ok=%0b target=%08h, got ok=%0b target=%08h",
                     want.ok, want.target, out_data_o.ok, out_data_o.target);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int i;
    int waited;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    failures = 0;
    tx_gap_max = 10;
    rx_stall_max = 10;
    for (i = 0; i < RING_SLOTS; i++) begin
      nav_slots[i] = '0;
    end
    oldest_idx = '0;
    newest_idx = '0;
    here_idx = '0;
    pos_pool[0] = 32'h0000_0000;
    pos_pool[1] = 32'hFFFF_FFFF;
    pos_pool[2] = 32'h0000_0001;
    pos_pool[3] = 32'h8000_0000;
    for (i = 4; i < 8; i++) begin
      pos_pool[i] = $urandom;
    end
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_history();
    test_save_and_walk();
    test_back_append();
    test_wraparound();
    test_backpressure();
    test_random_walk();

    in_valid_i = 1'b0;
    waited = 0;
    while (pending_moves.size() > 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (failures == 0 && pending_moves.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/nhr_pkg.sv
src/nhr_ctrl.sv
src/nhr_datapath.sv
src/navigation_history_ring.sv
src/nhr_checker.sv
tb/sv/navigation_history_ring_test.sv
